// ===== sv/mtmb_pkg.sv =====
// Package: types, constants and helpers for the model matrix builder
`timescale 1ns / 1ps
package mtmb_pkg;

   localparam int CordicStages = 16;
   localparam int TurnUnits    = 23040;
   localparam int HalfTurn     = 11520;
   localparam int QuarterTurn  = 5760;
   localparam int CordicGain   = 652032874;
   localparam int QueueDepth   = 4;
   localparam int QueueAw      = $clog2(QueueDepth);

   typedef struct packed {
      logic signed [31:0] translate_x;
      logic signed [31:0] translate_y;
      logic signed [31:0] translate_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m03;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m13;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] m23;
   } rsp_type;

   // reduced angle: residual in [-5760,5760] plus cosine flip
   typedef struct packed {
      logic signed [13:0] res;
      logic               flip;
   } red_type;

   // front to back queue word
   typedef struct packed {
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] sz;
      red_type            ax;
      red_type            ay;
      red_type            az;
   } cls_type;

   typedef struct packed {
      logic push;
      logic full;
      logic pop;
      logic empty;
   } qstat_type;

   function automatic logic signed [33:0] atan_turn(input int i);
      case (i)
         0: atan_turn = 34'sd536870912;
         1: atan_turn = 34'sd316933406;
         2: atan_turn = 34'sd167458907;
         3: atan_turn = 34'sd85004756;
         4: atan_turn = 34'sd42667331;
         5: atan_turn = 34'sd21354465;
         6: atan_turn = 34'sd10679838;
         7: atan_turn = 34'sd5340245;
         8: atan_turn = 34'sd2670163;
         9: atan_turn = 34'sd1335087;
         10: atan_turn = 34'sd667544;
         11: atan_turn = 34'sd333772;
         12: atan_turn = 34'sd166886;
         13: atan_turn = 34'sd83443;
         14: atan_turn = 34'sd41722;
         15: atan_turn = 34'sd20861;
         16: atan_turn = 34'sd10430;
         17: atan_turn = 34'sd5215;
         18: atan_turn = 34'sd2608;
         19: atan_turn = 34'sd1304;
         20: atan_turn = 34'sd652;
         21: atan_turn = 34'sd326;
         22: atan_turn = 34'sd163;
         23: atan_turn = 34'sd81;
         24: atan_turn = 34'sd41;
         25: atan_turn = 34'sd20;
         26: atan_turn = 34'sd10;
         27: atan_turn = 34'sd5;
         28: atan_turn = 34'sd3;
         29: atan_turn = 34'sd1;
         30: atan_turn = 34'sd1;
         default: atan_turn = 34'sd0;
      endcase
   endfunction

   // 16-bit angle into the residual and flip; mod 23040 by compare and subtract
   function automatic red_type reduce_angle(input logic signed [15:0] a);
      logic signed [17:0] r;
      red_type o;
      r = 18'(a);
      // |a| <= 32768 < 2*23040, so at most one turn to remove on either side
      if (r > 18'sd11520) r = r - 18'(TurnUnits);
      if (r > 18'sd11520) r = r - 18'(TurnUnits);
      if (r <= -18'sd11520) r = r + 18'(TurnUnits);
      if (r <= -18'sd11520) r = r + 18'(TurnUnits);
      o.flip = 1'b0;
      if (r > 18'sd5760) begin
         r = 18'(HalfTurn) - r;
         o.flip = 1'b1;
      end else if (r < -18'sd5760) begin
         r = -18'(HalfTurn) - r;
         o.flip = 1'b1;
      end
      o.res = r[13:0];
      return o;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ===== sv/model_transform_matrix_builder.sv =====
// Top level: model matrix builder (translate * rotate * scale)
//  channel | ports                 | direction
//  request | req_valid/stall/data  | in
//  result  | rsp_valid/stall/data  | out
// One word per cycle sustained while the result channel does not stall; an accepted word
// passes the front register and the queue, then the 22-stage back pipe to rsp_valid.
// Latency is set by the 16-stage CORDIC pipelines and the product stages.
// Reset is synchronous and clears valid bits and the queue pointers and count only.
// A result stall while rsp_valid is high freezes the back pipe; the queue soaks up words in flight.
`timescale 1ns / 1ps
module model_transform_matrix_builder
   import mtmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      q_push, q_pop;
   cls_type   q_in, q_out;
   qstat_type qs;

   mtmb_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_full(qs.full), .q_push, .q_data(q_in)
   );

   mtmb_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in),
      .pop(q_pop), .pop_data(q_out), .stat(qs)
   );

   mtmb_back u_back (
      .clock, .reset, .q_empty(qs.empty), .q_pop, .q_data(q_out),
      .rsp_valid, .rsp_stall, .rsp_data
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qs.full |-> !qs.push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qs.empty |-> !qs.pop) else $error("pop from empty queue");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

endmodule

// ===== sv/mtmb_front.sv =====
// Front end: takes request words, reduces the angles and pushes to the queue
`timescale 1ns / 1ps
module mtmb_front
   import mtmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cls_type q_data
);

   logic    valid_ff;
   cls_type word_ff;
   cls_type word_in;

   assign req_stall = valid_ff && q_full;
   assign q_push    = valid_ff && !q_full;
   assign q_data    = word_ff;

   always_comb begin
      word_in.tx = req_data.translate_x;
      word_in.ty = req_data.translate_y;
      word_in.tz = req_data.translate_z;
      word_in.sx = req_data.scale_x;
      word_in.sy = req_data.scale_y;
      word_in.sz = req_data.scale_z;
      word_in.ax = reduce_angle(req_data.angle_x);
      word_in.ay = reduce_angle(req_data.angle_y);
      word_in.az = reduce_angle(req_data.angle_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== sv/mtmb_queue.sv =====
// Short queue between front and back ends
`timescale 1ns / 1ps
module mtmb_queue
   import mtmb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cls_type   push_data,
   input  logic      pop,
   output cls_type   pop_data,
   output qstat_type stat
);

   cls_type            mem_ff [QueueDepth];
   logic [QueueAw-1:0] wp_ff, rp_ff;
   logic [QueueAw:0]   cnt_ff;

   assign pop_data   = mem_ff[rp_ff];
   assign stat.full  = (cnt_ff == (QueueAw+1)'(QueueDepth));
   assign stat.empty = (cnt_ff == '0);
   assign stat.push  = push;
   assign stat.pop   = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// ===== sv/mtmb_cordic.sv =====
// Pipelined rotation CORDIC: residual angle to Q1.16 (18-bit signed) sine and cosine
`timescale 1ns / 1ps
module mtmb_cordic
   import mtmb_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  red_type            ang,
   output logic signed [17:0] sin_q,
   output logic signed [17:0] cos_q
);

   logic signed [33:0] x_ff [CordicStages+1];
   logic signed [33:0] y_ff [CordicStages+1];
   logic signed [33:0] z_ff [CordicStages+1];
   logic               f_ff [CordicStages+1];
   logic signed [17:0] s_ff, c_ff;
   logic [36:0]        prod;
   logic signed [33:0] z0;
   logic [12:0]        mag;
   logic signed [33:0] xr, yr;
   logic signed [17:0] xc, yc;

   // z = floor((mag * 2^23 + 22) / 45), by a reciprocal and one correction step
   always_comb begin
      logic [36:0] num;
      logic [36:0] q;
      mag = ang.res[13] ? 13'(-ang.res) : ang.res[12:0];
      num = {1'b0, mag, 23'd0} + 37'd22;
      q   = 37'((68'(num) * 68'd1527099483) >> 36);
      if (num - q * 37'd45 >= 37'd45) q = q + 37'd1;
      prod = q;
      z0 = ang.res[13] ? -34'(prod) : 34'(prod);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= 34'(CordicGain);
         y_ff[0] <= '0;
         z_ff[0] <= z0;
         f_ff[0] <= ang.flip;
      end
   end

   for (genvar i = 0; i < CordicStages; i++) begin : g_st
      always_ff @(posedge clock) begin
         if (en) begin
            f_ff[i+1] <= f_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end
         end
      end
   end

   always_comb begin
      xr = (x_ff[CordicStages] + 34'sd8192) >>> 14;
      yr = (y_ff[CordicStages] + 34'sd8192) >>> 14;
      xc = (xr > 34'sd65536) ? 18'sd65536 : (xr < -34'sd65536) ? -18'sd65536 : xr[17:0];
      yc = (yr > 34'sd65536) ? 18'sd65536 : (yr < -34'sd65536) ? -18'sd65536 : yr[17:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= f_ff[CordicStages] ? -xc : xc;
         s_ff <= yc;
      end
   end

   assign sin_q = s_ff;
   assign cos_q = c_ff;

endmodule

// ===== sv/mtmb_back.sv =====
// Back end: CORDICs, matrix products, scaling and output register
`timescale 1ns / 1ps
module mtmb_back
   import mtmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   output logic    q_pop,
   input  cls_type q_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // cordic: 1 + stages + 1, then product stages A and B, scale and output registers
   localparam int Lat = CordicStages + 6;

   logic                en;
   logic [Lat-1:0]      vld_ff;
   cls_type             pass_ff [Lat];
   logic signed [17:0]  sxv, cxv, syv, cyv, szv, czv;

   // whole pipe advances together; output word at last stage
   assign en        = !(vld_ff[Lat-1] && rsp_stall);
   assign q_pop     = en && !q_empty;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], q_pop};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass_ff[0] <= q_data;
         for (int k = 1; k < Lat; k++) pass_ff[k] <= pass_ff[k-1];
      end
   end

   mtmb_cordic u_cx (.clock, .en, .ang(q_data.ax), .sin_q(sxv), .cos_q(cxv));
   mtmb_cordic u_cy (.clock, .en, .ang(q_data.ay), .sin_q(syv), .cos_q(cyv));
   mtmb_cordic u_cz (.clock, .en, .ang(q_data.az), .sin_q(szv), .cos_q(czv));

   // stage A: pairwise Q32 products
   logic signed [35:0] zy_cc, zy_cs, zy_sc, zy_ss, zx_cc, zx_cs, zx_sc, zx_ss;
   logic signed [35:0] yx_cs, yx_cc;
   logic signed [17:0] sx_a, cx_a, sy_a, cy_a;
   always_ff @(posedge clock) begin
      if (en) begin
         zy_cc <= czv * cyv;  zy_cs <= czv * syv;
         zy_sc <= szv * cyv;  zy_ss <= szv * syv;
         zx_cc <= czv * cxv;  zx_cs <= szv * cxv;
         zx_sc <= czv * sxv;  zx_ss <= szv * sxv;
         yx_cs <= cyv * sxv;  yx_cc <= cyv * cxv;
         sx_a <= sxv; cx_a <= cxv; sy_a <= syv; cy_a <= cyv;
      end
   end

   // stage B: Q48 entries, then round to Q30
   logic signed [31:0] rq_ff [9];
   logic signed [63:0] q48 [9];
   always_comb begin
      q48[0] = 64'(zy_cc) <<< 16;
      q48[1] = 64'(zy_cs) * 64'(sx_a) - (64'(zx_cs) <<< 16);
      q48[2] = 64'(zy_cs) * 64'(cx_a) + (64'(zx_ss) <<< 16);
      q48[3] = 64'(zy_sc) <<< 16;
      q48[4] = 64'(zy_ss) * 64'(sx_a) + (64'(zx_cc) <<< 16);
      q48[5] = 64'(zy_ss) * 64'(cx_a) - (64'(zx_sc) <<< 16);
      q48[6] = -(64'(sy_a) <<< 32);
      q48[7] = 64'(yx_cs) <<< 16;
      q48[8] = 64'(yx_cc) <<< 16;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            rq_ff[k] <= 32'((q48[k] + 64'sd131072) >>> 18);
         end
      end
   end

   // stage C: scale and saturate
   logic signed [63:0] sc_p [9];
   cls_type            pc;
   assign pc = pass_ff[Lat-3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sc_p[r*3+0] = 64'(rq_ff[r*3+0]) * 64'(pc.sx);
         sc_p[r*3+1] = 64'(rq_ff[r*3+1]) * 64'(pc.sy);
         sc_p[r*3+2] = 64'(rq_ff[r*3+2]) * 64'(pc.sz);
      end
   end

   logic signed [31:0] m_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= sat32((sc_p[k] + 64'sd536870912) >>> 30);
         end
      end
   end

   cls_type po;
   assign po = pass_ff[Lat-1];
   logic signed [31:0] o_ff [9];
   always_ff @(posedge clock) begin
      if (en) for (int k = 0; k < 9; k++) o_ff[k] <= m_ff[k];
   end

   always_comb begin
      rsp_data.m00 = o_ff[0]; rsp_data.m01 = o_ff[1]; rsp_data.m02 = o_ff[2];
      rsp_data.m10 = o_ff[3]; rsp_data.m11 = o_ff[4]; rsp_data.m12 = o_ff[5];
      rsp_data.m20 = o_ff[6]; rsp_data.m21 = o_ff[7]; rsp_data.m22 = o_ff[8];
      rsp_data.m03 = po.tx;   rsp_data.m13 = po.ty;   rsp_data.m23 = po.tz;
   end

endmodule
